// ===== hw/rtl/mmsq_pkg.sv =====
package mmsq_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int FRAC_W    = 16;
    localparam int MAX_DIMS  = 1024;
    localparam int ADDR_W    = $clog2(MAX_DIMS);
    localparam int CFG_W     = ADDR_W + 1;

    localparam int CODE_W    = 8;
    localparam int QUOT_BITS = CODE_W;
    localparam int QCNT_W    = $clog2(QUOT_BITS);

    // Extended difference/range: one extra bit for the sign.
    localparam int DIFF_W    = SAMPLE_W + 1;
    // Rounded dividend 2*255*diff + range, and divisor 2*range.
    localparam int NUM_W     = SAMPLE_W + 10;
    localparam int DEN_W     = SAMPLE_W + 1;

    localparam int S_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 2;
    localparam int M_FIELD_W = CODE_W + ADDR_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};

    localparam logic MODE_TRAIN    = 1'b0;
    localparam logic MODE_QUANTIZE = 1'b1;

endpackage

// ===== hw/rtl/mmsq_divider.sv =====
module mmsq_divider
    import mmsq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [DEN_W-1:0]    i_den,
    output logic                o_done,
    output logic [QUOT_BITS-1:0] o_quot
);

    logic                 r_busy,  n_busy;
    logic                 r_done,  n_done;
    logic [QCNT_W-1:0]    r_cnt,   n_cnt;
    logic [NUM_W-1:0]     r_rem,   n_rem;
    logic [NUM_W-1:0]     r_dsh,   n_dsh;
    logic [QUOT_BITS-1:0] r_quot,  n_quot;

    // Restoring division, one quotient bit per cycle, most significant first.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = QCNT_W'(QUOT_BITS - 1);
            n_rem  = i_num;
            n_dsh  = NUM_W'(i_den) << (QUOT_BITS - 1);
            n_quot = '0;
        end else if (r_busy) begin
            if (r_rem >= r_dsh) begin
                n_rem  = r_rem - r_dsh;
                n_quot = {r_quot[QUOT_BITS-2:0], 1'b1};
            end else begin
                n_quot = {r_quot[QUOT_BITS-2:0], 1'b0};
            end
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/minmax_scalar_quantizer_u8.sv =====
// Per-dimension 8-bit min/max scalar quantizer for signed Q16.16 samples.
// Slave stream: s_axis_tdata carries the sample, s_axis_tuser the mode
// (bit 0: 0 = train, 1 = quantize) and batch_start (bit 1), which restarts
// the dimension position. Training elements update the per-dimension min
// and max tables and produce no output transaction; quantize elements
// produce one transaction on the master stream with the code, the
// dimension position and tlast on the last dimension of a vector.
// The user must write the dimension count (i_cfg_we / i_cfg_wdata) only
// while idle; the block does not enforce it. Elements are processed one at
// a time: s_axis_tready is high only in the idle state. A training element
// reads the tables on accept and writes them back in evaluate. Quantize
// elements pass evaluate, prepare, divide (skipped for code 0, zero range
// or saturation) and done; restoring division: one quotient bit per cycle.
// Results sit in an output register; a stalled receiver holds it, and a
// new result waits in the done state until that register frees up.
// Reset (synchronous, active low) clears the position, the first-row flag,
// the output valid, and sets the dimension count to 1. Table contents are
// undefined until trained; no clearing pass runs.
module minmax_scalar_quantizer_u8
    import mmsq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration: dims_in_use
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // Input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [31:0] sample
    input  logic [S_TUSER_W-1:0] s_axis_tuser,   // [0] mode, [1] batch_start
    // Output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [7:0] code, [17:8] dim_position
    output logic                 m_axis_tlast    // row_end
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // Dimension count and position tracking
    logic [CFG_W-1:0]    r_dims;
    logic [ADDR_W-1:0]   r_position, n_position;
    logic                r_first_row, n_first_row;
    logic [CFG_W-1:0]    eff_dims;

    // Transaction held while it is processed
    logic                r_mode,   n_mode;
    logic                r_load,   n_load;
    logic                r_last,   n_last;
    logic [ADDR_W-1:0]   r_pos,    n_pos;
    logic signed [SAMPLE_W-1:0] r_x, n_x;

    // Table storage and registered read data
    logic signed [SAMPLE_W-1:0] r_min_mem [MAX_DIMS];
    logic signed [SAMPLE_W-1:0] r_max_mem [MAX_DIMS];
    logic signed [SAMPLE_W-1:0] r_min_rd;
    logic signed [SAMPLE_W-1:0] r_max_rd;
    logic                       tbl_we;
    logic signed [SAMPLE_W-1:0] tbl_min_wd;
    logic signed [SAMPLE_W-1:0] tbl_max_wd;

    // Quantize datapath
    logic signed [DIFF_W-1:0] r_diff,  n_diff;
    logic signed [DIFF_W-1:0] r_range, n_range;
    logic [CODE_W-1:0]        r_code,  n_code;
    logic [SAMPLE_W:0]        round_sum;
    logic [SAMPLE_W-FRAC_W:0] round_q;
    logic [NUM_W-1:0]         div_num;
    logic [DEN_W-1:0]         div_den;
    logic                     div_start;
    logic                     div_done;
    logic [QUOT_BITS-1:0]     div_quot;

    // Output register
    logic                r_m_valid, n_m_valid;
    logic [CODE_W-1:0]   r_m_code,  n_m_code;
    logic [ADDR_W-1:0]   r_m_pos,   n_m_pos;
    logic                r_m_last,  n_m_last;

    logic s_accept;
    logic in_mode;
    logic in_batch;
    logic [ADDR_W-1:0] pos_base;
    logic [ADDR_W-1:0] cur_pos;
    logic              cur_last;
    logic              frp_mid;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_mode       = s_axis_tuser[0];
    assign in_batch      = s_axis_tuser[1];

    // Clamp the dimension count into 1..MAX_DIMS.
    always_comb begin
        if (r_dims == '0) begin
            eff_dims = CFG_W'(1);
        end else if (r_dims > CFG_W'(MAX_DIMS)) begin
            eff_dims = CFG_W'(MAX_DIMS);
        end else begin
            eff_dims = r_dims;
        end
    end

    // Position of the incoming element; restart on batch start or when the
    // count was lowered below the current position.
    always_comb begin
        pos_base = in_batch ? '0 : r_position;
        frp_mid  = in_batch ? (in_mode == MODE_TRAIN) : r_first_row;
        cur_pos  = ({1'b0, pos_base} >= eff_dims) ? '0 : pos_base;
        cur_last = ({1'b0, cur_pos} == (eff_dims - 1'b1));
    end

    // Rounding for the unit-scale path: round the Q16.16 difference.
    assign round_sum = {1'b0, r_diff[SAMPLE_W-1:0]} + (SAMPLE_W+1)'(1 << (FRAC_W - 1));
    assign round_q   = round_sum[SAMPLE_W:FRAC_W];

    // Dividend 2*255*diff + range and divisor 2*range give the quotient
    // rounded half up, which equals half away from zero for positive values.
    assign div_num = (NUM_W'(r_diff[SAMPLE_W-1:0]) << 9)
                   - (NUM_W'(r_diff[SAMPLE_W-1:0]) << 1)
                   + NUM_W'(r_range[SAMPLE_W-1:0]);
    assign div_den = {r_range[SAMPLE_W-1:0], 1'b0};

    always_comb begin
        n_state     = r_state;
        n_position  = r_position;
        n_first_row = r_first_row;
        n_mode      = r_mode;
        n_load      = r_load;
        n_last      = r_last;
        n_pos       = r_pos;
        n_x         = r_x;
        n_diff      = r_diff;
        n_range     = r_range;
        n_code      = r_code;
        n_m_valid   = r_m_valid;
        n_m_code    = r_m_code;
        n_m_pos     = r_m_pos;
        n_m_last    = r_m_last;
        tbl_we      = 1'b0;
        tbl_min_wd  = r_min_rd;
        tbl_max_wd  = r_max_rd;
        div_start   = 1'b0;

        // Drop the held result once the receiver takes it.
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_mode      = in_mode;
                    n_x         = s_axis_tdata[SAMPLE_W-1:0];
                    n_pos       = cur_pos;
                    n_last      = cur_last;
                    n_load      = frp_mid;
                    n_first_row = (in_mode == MODE_TRAIN && cur_last) ? 1'b0 : frp_mid;
                    n_position  = cur_last ? '0 : cur_pos + 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_mode == MODE_TRAIN) begin
                    // First row loads both bounds; later rows widen them.
                    tbl_we = 1'b1;
                    if (r_load) begin
                        tbl_min_wd = r_x;
                        tbl_max_wd = r_x;
                    end else begin
                        tbl_min_wd = (r_x < r_min_rd) ? r_x : r_min_rd;
                        tbl_max_wd = (r_x > r_max_rd) ? r_x : r_max_rd;
                    end
                    n_state = S_IDLE;
                end else begin
                    n_diff  = DIFF_W'(r_x) - DIFF_W'(r_min_rd);
                    n_range = DIFF_W'(r_max_rd) - DIFF_W'(r_min_rd);
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_diff <= 0) begin
                    n_code  = '0;
                    n_state = S_DONE;
                end else if (r_range <= 0) begin
                    n_code  = (round_q > (SAMPLE_W-FRAC_W+1)'(CODE_MAX))
                            ? CODE_MAX : round_q[CODE_W-1:0];
                    n_state = S_DONE;
                end else if (r_diff > r_range) begin
                    n_code  = CODE_MAX;
                    n_state = S_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_code  = div_quot;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Advance only when the output register is free.
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_code  = r_code;
                    n_m_pos   = r_pos;
                    n_m_last  = r_last;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dims      <= CFG_W'(1);
            r_position  <= '0;
            r_first_row <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_dims <= i_cfg_wdata;
            end
            r_position  <= n_position;
            r_first_row <= n_first_row;
            r_m_valid   <= n_m_valid;
        end
        r_mode   <= n_mode;
        r_load   <= n_load;
        r_last   <= n_last;
        r_pos    <= n_pos;
        r_x      <= n_x;
        r_diff   <= n_diff;
        r_range  <= n_range;
        r_code   <= n_code;
        r_m_code <= n_m_code;
        r_m_pos  <= n_m_pos;
        r_m_last <= n_m_last;
    end

    // Tables: read on accept, write back in the evaluate cycle.
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_min_mem[r_pos] <= tbl_min_wd;
        end
        if (s_accept) begin
            r_min_rd <= r_min_mem[cur_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_max_mem[r_pos] <= tbl_max_wd;
        end
        if (s_accept) begin
            r_max_rd <= r_max_mem[cur_pos];
        end
    end

    mmsq_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_m_pos, r_m_code});
    assign m_axis_tlast  = r_m_last;

endmodule
